// ===== hdl/fcsg_pkg.sv =====
// shared types and constants for the filled circle span generator
`default_nettype none

package fcsg_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int MAX_SPANS   = 4;
    localparam int SLOT_BITS   = $clog2(MAX_SPANS);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef enum logic
    {
        FUNC_START   = 1'b0,
        FUNC_ADVANCE = 1'b1
    } func_t;

    typedef struct packed
    {
        func_t  func;
        coord_t center_x;
        coord_t center_y;
        coord_t radius;
    } req_t;

    typedef struct packed
    {
        logic   span_valid;
        coord_t span_left;
        coord_t span_right;
        coord_t span_row;
        logic   last;
        logic   done_res;
    } res_t;

    typedef struct packed
    {
        coord_t left;
        coord_t right;
        coord_t row;
    } span_t;

    localparam coord_t COORD_ONES  = '1;
    localparam coord_t DELTA_E_INIT = coord_t'(3);

endpackage

`default_nettype wire

// ===== hdl/filled_circle_span_generator.sv =====
// midpoint filled circle rasteriser emitting horizontal spans
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+----------------------------------------
//  request | req_valid | req_stall | req : func, center_x, center_y, radius
//  result  | res_valid | res_stall | res : span, last, done_res
//
// one request register feeds the iteration logic, which fills a four entry
// span buffer at once; the buffer drains one result per cycle while res_stall
// is low. an item gives 1 to 4 results, and the next item is loaded as the
// last result leaves.
// reset clears the circle state but sets delta_e to three; prior sentinels go to all ones.
// a stalled result holds the buffer; the request register holds one more item.
`default_nettype none

module filled_circle_span_generator
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output      logic           req_stall,
    input  wire fcsg_pkg::req_t req,
    output      logic           res_valid,
    input  wire logic           res_stall,
    output      fcsg_pkg::res_t res
);
    import fcsg_pkg::*;

    // request register
    logic   req_valid_reg;
    req_t   req_reg;

    // circle state
    logic   active_reg, active_next;
    coord_t center_col_reg, center_col_next;
    coord_t center_row_reg, center_row_next;
    coord_t step_x_reg, step_x_next;
    coord_t step_y_reg, step_y_next;
    coord_t prior_x_reg, prior_x_next;
    coord_t prior_y_reg, prior_y_next;
    coord_t decision_reg, decision_next;
    coord_t delta_e_reg, delta_e_next;
    coord_t delta_se_reg, delta_se_next;

    // span buffer
    logic                 buf_valid_reg;
    logic [SLOT_BITS-1:0] idx_reg;
    logic [SLOT_BITS-1:0] last_idx_reg, last_idx_next;
    logic                 empty_reg, empty_next;
    logic                 done_reg;
    span_t                span_reg [MAX_SPANS];
    span_t                span_next [MAX_SPANS];

    logic   res_take, finishing, load, run, is_start;
    coord_t cx, cy, x, y, df, de, dse, px, py;
    coord_t cx_new, cy_new;
    span_t  a0, a1, b0, b1;
    logic [1:0] a_n, b_n;
    logic [2:0] n_spans;

    assign res_take  = buf_valid_reg && !res_stall;
    assign finishing = res_take && (idx_reg == last_idx_reg);
    assign load      = req_valid_reg && (!buf_valid_reg || finishing);
    assign req_stall = req_valid_reg && !load;

    always_comb
    begin
        is_start = (req_reg.func == FUNC_START);
        run      = is_start ? (req_reg.radius > 0) : active_reg;

        if (is_start)
        begin
            x   = req_reg.center_x;
            y   = req_reg.center_y;
            cx  = '0;
            cy  = req_reg.radius;
            px  = COORD_ONES;
            py  = COORD_ONES;
            df  = coord_t'(1) - req_reg.radius;
            de  = DELTA_E_INIT;
            dse = coord_t'(5) - (req_reg.radius <<< 1);
        end
        else
        begin
            x   = center_col_reg;
            y   = center_row_reg;
            cx  = step_x_reg;
            cy  = step_y_reg;
            px  = prior_x_reg;
            py  = prior_y_reg;
            df  = decision_reg;
            de  = delta_e_reg;
            dse = delta_se_reg;
        end

        a0 = '{left: x - cx, right: x + cx, row: (cy > 0) ? y + cy : y};
        a1 = '{left: x - cx, right: x + cx, row: y - cy};
        b0 = '{left: x - cy, right: x + cy, row: (cx > 0) ? y - cx : y};
        b1 = '{left: x - cy, right: x + cy, row: y + cx};

        a_n = (py != cy) ? ((cy > 0) ? 2'd2 : 2'd1) : 2'd0;
        b_n = ((px != cx) && (cx != cy)) ? ((cx > 0) ? 2'd2 : 2'd1) : 2'd0;
        n_spans = {1'b0, a_n} + {1'b0, b_n};

        for (int i = 0; i < MAX_SPANS; i++)
        begin
            span_next[i] = '0;
        end
        case (a_n)
            2'd0:
            begin
                span_next[0] = b0;
                span_next[1] = b1;
            end
            2'd1:
            begin
                span_next[0] = a0;
                span_next[1] = b0;
                span_next[2] = b1;
            end
            default:
            begin
                span_next[0] = a0;
                span_next[1] = a1;
                span_next[2] = b0;
                span_next[3] = b1;
            end
        endcase

        // midpoint update
        cx_new = cx + coord_t'(1);
        cy_new = (df < 0) ? cy : cy - coord_t'(1);

        active_next     = active_reg;
        center_col_next = center_col_reg;
        center_row_next = center_row_reg;
        step_x_next     = step_x_reg;
        step_y_next     = step_y_reg;
        prior_x_next    = prior_x_reg;
        prior_y_next    = prior_y_reg;
        decision_next   = decision_reg;
        delta_e_next    = delta_e_reg;
        delta_se_next   = delta_se_reg;

        if (run)
        begin
            active_next     = (cx_new <= cy_new);
            center_col_next = x;
            center_row_next = y;
            step_x_next     = cx_new;
            step_y_next     = cy_new;
            prior_x_next    = cx;
            prior_y_next    = cy;
            decision_next   = (df < 0) ? df + de : df + dse;
            delta_e_next    = de + coord_t'(2);
            delta_se_next   = (df < 0) ? dse + coord_t'(2) : dse + coord_t'(4);
        end
        else if (is_start)
        begin
            active_next = 1'b0;
        end

        empty_next    = !run || (n_spans == 3'd0);
        last_idx_next = empty_next ? '0 : SLOT_BITS'(n_spans - 3'd1);
        if (empty_next)
        begin
            span_next[0] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg  <= 1'b0;
            buf_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            active_reg     <= 1'b0;
            center_col_reg <= '0;
            center_row_reg <= '0;
            step_x_reg     <= '0;
            step_y_reg     <= '0;
            prior_x_reg    <= COORD_ONES;
            prior_y_reg    <= COORD_ONES;
            decision_reg   <= '0;
            delta_e_reg    <= DELTA_E_INIT;
            delta_se_reg   <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                req_valid_reg <= 1'b1;
            end
            else if (load)
            begin
                req_valid_reg <= 1'b0;
            end

            if (load)
            begin
                buf_valid_reg  <= 1'b1;
                idx_reg        <= '0;
                active_reg     <= active_next;
                center_col_reg <= center_col_next;
                center_row_reg <= center_row_next;
                step_x_reg     <= step_x_next;
                step_y_reg     <= step_y_next;
                prior_x_reg    <= prior_x_next;
                prior_y_reg    <= prior_y_next;
                decision_reg   <= decision_next;
                delta_e_reg    <= delta_e_next;
                delta_se_reg   <= delta_se_next;
            end
            else if (finishing)
            begin
                buf_valid_reg <= 1'b0;
            end
            else if (res_take)
            begin
                idx_reg <= idx_reg + SLOT_BITS'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            req_reg <= req;
        end
        if (load)
        begin
            for (int i = 0; i < MAX_SPANS; i++)
            begin
                span_reg[i] <= span_next[i];
            end
            last_idx_reg <= last_idx_next;
            empty_reg    <= empty_next;
            done_reg     <= !active_next;
        end
    end

    assign res_valid       = buf_valid_reg;
    assign res.span_valid  = !empty_reg;
    assign res.span_left   = span_reg[idx_reg].left;
    assign res.span_right  = span_reg[idx_reg].right;
    assign res.span_row    = span_reg[idx_reg].row;
    assign res.last        = (idx_reg == last_idx_reg);
    assign res.done_res    = done_reg;

    // the read slot never runs past the last filled slot
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        buf_valid_reg |-> (idx_reg <= last_idx_reg))
        else $error("span index beyond last slot");

    // an empty result is always the only result of its transaction
    a_empty_single: assert property (@(posedge clk) disable iff (!rst_n)
        (buf_valid_reg && empty_reg) |-> (last_idx_reg == '0))
        else $error("empty result with further results");

    // an active circle keeps step_x no greater than step_y
    a_active_order: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (step_x_reg <= step_y_reg))
        else $error("active circle with step_x above step_y");

    // a stalled result does not advance the buffer
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (buf_valid_reg && res_stall) |=> (buf_valid_reg && $stable(idx_reg)))
        else $error("span buffer moved under stall");

endmodule

`default_nettype wire
